/* rtl/core/afs_pkg.sv */
// afs_pkg: shared types, constants and the arctangent table for armor_face_selector.
// Used by afs_front, afs_back and the top level; depends on nothing.
`default_nettype none

package afs_pkg;

	// stream layout
	localparam int S_TDATA_W  = 120;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 8;
	localparam int M_TUSER_W  = 1;

	localparam int XY_W       = 24;
	localparam int ANG_W      = 16;
	localparam int COUNT_W    = 3;
	localparam int SPIN_W     = 2;
	localparam int IDX_W      = 2;
	localparam int MAX_FACES  = 4;

	localparam int CX_LSB     = 0;
	localparam int CY_LSB     = 24;
	localparam int YAW_LSB    = 48;
	localparam int COUNT_LSB  = 112;
	localparam int SPIN_LSB   = 115;
	localparam int LOCK_BIT   = 0;
	localparam int OUTPOST_BIT = 1;

	// datapath
	localparam int CW         = 27;   // CORDIC x/y width
	localparam int ZW         = 24;   // angle accumulator, 2^24 per turn
	localparam int STEP_W     = 5;
	localparam int DELTA_W    = ANG_W + 1;
	localparam logic [ANG_W-1:0] LOCK_LIMIT = 16'd10921;
	localparam logic [ANG_W-1:0] HALF_TURN  = 16'd32768;

	// configuration
	localparam int CFG_W      = 15;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_W-1:0] COMING_RST  = 15'd910;
	localparam logic [CFG_W-1:0] LEAVING_RST = 15'd910;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COMING  = 1'b0,
		REG_LEAVING = 1'b1
	} reg_idx_t;

	// parameter defaults
	localparam int FACE_SLOTS_DEF   = 4;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 2;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_RUN,
		FR_PUSH
	} front_state_t;

	typedef struct packed {
		logic [SPIN_W-1:0] spin;
		logic              lock_mode;
		logic              is_outpost;
	} mode_t;

	localparam int MODE_W = $bits(mode_t);

	function automatic logic [ZW-1:0] atan_step(input logic [STEP_W-1:0] idx);
		logic [ZW-1:0] r;
		case (idx)
			5'd0:  r = 24'd2097152;
			5'd1:  r = 24'd1238021;
			5'd2:  r = 24'd654136;
			5'd3:  r = 24'd332050;
			5'd4:  r = 24'd166669;
			5'd5:  r = 24'd83416;
			5'd6:  r = 24'd41718;
			5'd7:  r = 24'd20860;
			5'd8:  r = 24'd10430;
			5'd9:  r = 24'd5215;
			5'd10: r = 24'd2608;
			5'd11: r = 24'd1304;
			5'd12: r = 24'd652;
			5'd13: r = 24'd326;
			5'd14: r = 24'd163;
			5'd15: r = 24'd81;
			5'd16: r = 24'd41;
			5'd17: r = 24'd20;
			5'd18: r = 24'd10;
			5'd19: r = 24'd5;
			5'd20: r = 24'd3;
			5'd21: r = 24'd1;
			5'd22: r = 24'd1;
			default: r = 24'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/afs_front.sv */
// afs_front: takes an input transfer, runs the iterative CORDIC bearing and
// computes the wrapped face deltas into one queue entry. Depends on afs_pkg.
`default_nettype none

module afs_front #(
	parameter int FACE_SLOTS   = afs_pkg::FACE_SLOTS_DEF,
	parameter int CORDIC_STEPS = afs_pkg::CORDIC_STEPS_DEF,
	parameter int ENTRY_W      = FACE_SLOTS * afs_pkg::DELTA_W + FACE_SLOTS + afs_pkg::MODE_W
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire logic [afs_pkg::S_TDATA_W-1:0]  in_data,
	input  wire logic [afs_pkg::S_TUSER_W-1:0]  in_user,
	output      logic                           push_valid,
	input  wire logic                           push_ready,
	output      logic [ENTRY_W-1:0]             push_data
);

	afs_pkg::front_state_t state_q, state_d;

	logic signed [afs_pkg::CW-1:0]      x_q, y_q;
	logic        [afs_pkg::ZW-1:0]      z_q;
	logic                               origin_q;
	logic        [afs_pkg::STEP_W-1:0]  step_q;
	logic        [afs_pkg::ANG_W-1:0]   yaw_q [FACE_SLOTS];
	logic        [FACE_SLOTS-1:0]       mask_q;
	afs_pkg::mode_t                     mode_q;

	logic                               load;
	logic                               run;
	logic                               last_step;
	logic signed [afs_pkg::CW-1:0]      x_in, y_in, dx, dy;
	logic        [afs_pkg::COUNT_W-1:0] count_in, count_sat;
	logic        [afs_pkg::ZW-1:0]      z_round;
	logic        [afs_pkg::ANG_W-1:0]   bearing;
	logic        [afs_pkg::ANG_W-1:0]   diff [FACE_SLOTS];
	logic                               y_pos;

	assign last_step = (step_q == afs_pkg::STEP_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afs_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		load       = 1'b0;
		run        = 1'b0;
		case (state_q)
			afs_pkg::FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load    = 1'b1;
					state_d = afs_pkg::FR_RUN;
				end
			end
			afs_pkg::FR_RUN: begin
				run = 1'b1;
				if (last_step) begin
					state_d = afs_pkg::FR_PUSH;
				end
			end
			afs_pkg::FR_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = afs_pkg::FR_IDLE;
				end
			end
			default: begin
				state_d = afs_pkg::FR_IDLE;
			end
		endcase
	end

	// input unpack and face-count saturation; the half-turn pre-rotation is applied at load
	always_comb begin
		x_in = afs_pkg::CW'($signed(in_data[afs_pkg::CX_LSB +: afs_pkg::XY_W]));
		y_in = afs_pkg::CW'($signed(in_data[afs_pkg::CY_LSB +: afs_pkg::XY_W]));
		count_in  = in_data[afs_pkg::COUNT_LSB +: afs_pkg::COUNT_W];
		count_sat = (count_in > afs_pkg::COUNT_W'(FACE_SLOTS)) ?
			afs_pkg::COUNT_W'(FACE_SLOTS) : count_in;
	end

	assign dx    = y_q >>> step_q;
	assign dy    = x_q >>> step_q;
	assign y_pos = !y_q[afs_pkg::CW-1] && (y_q != '0);

	always_ff @(posedge clk) begin
		if (load) begin
			if (x_in[afs_pkg::CW-1]) begin
				x_q <= -x_in;
				y_q <= -y_in;
				z_q <= afs_pkg::ZW'(1) << (afs_pkg::ZW - 1);
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
			origin_q <= (x_in == '0) && (y_in == '0);
			step_q   <= '0;
			for (int i = 0; i < FACE_SLOTS; i++) begin
				yaw_q[i]  <= in_data[afs_pkg::YAW_LSB + i * afs_pkg::ANG_W +: afs_pkg::ANG_W];
				mask_q[i] <= (count_sat > afs_pkg::COUNT_W'(i));
			end
			mode_q.spin       <= in_data[afs_pkg::SPIN_LSB +: afs_pkg::SPIN_W];
			mode_q.lock_mode  <= in_user[afs_pkg::LOCK_BIT];
			mode_q.is_outpost <= in_user[afs_pkg::OUTPOST_BIT];
		end else if (run) begin
			if (y_pos) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + afs_pkg::atan_step(step_q);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - afs_pkg::atan_step(step_q);
			end
			step_q <= step_q + 1'b1;
		end
	end

	// round to nearest BAM, then wrap each face delta into -32767..32768
	always_comb begin
		z_round = z_q + afs_pkg::ZW'(128);
		bearing = origin_q ? '0 : z_round[afs_pkg::ZW-1 -: afs_pkg::ANG_W];
		push_data = '0;
		push_data[0 +: afs_pkg::MODE_W] = mode_q;
		push_data[afs_pkg::MODE_W +: FACE_SLOTS] = mask_q;
		for (int i = 0; i < FACE_SLOTS; i++) begin
			diff[i] = yaw_q[i] - bearing;
			push_data[afs_pkg::MODE_W + FACE_SLOTS + i * afs_pkg::DELTA_W +: afs_pkg::DELTA_W] =
				{(diff[i] > afs_pkg::HALF_TURN), diff[i]};
		end
	end

endmodule

`default_nettype wire

/* rtl/core/afs_queue.sv */
// afs_queue: short register queue between the bearing front and the selection back.
// Depends on nothing but its parameters.
`default_nettype none

module afs_queue #(
	parameter int DEPTH   = 2,
	parameter int ENTRY_W = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output      logic               push_ready,
	input  wire logic [ENTRY_W-1:0] push_data,
	output      logic               pop_valid,
	input  wire logic               pop_ready,
	output      logic [ENTRY_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/afs_back.sv */
// afs_back: lock and window selection rules, sticky lock state and the output register.
// Consumes afs_queue entries built by afs_front; depends on afs_pkg.
`default_nettype none

module afs_back #(
	parameter int FACE_SLOTS = afs_pkg::FACE_SLOTS_DEF,
	parameter int ENTRY_W    = FACE_SLOTS * afs_pkg::DELTA_W + FACE_SLOTS + afs_pkg::MODE_W
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pop_valid,
	output      logic                           pop_ready,
	input  wire logic [ENTRY_W-1:0]             pop_data,
	input  wire logic [afs_pkg::CFG_W-1:0]      approach_lim,
	input  wire logic [afs_pkg::CFG_W-1:0]      depart_lim,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic                           out_found,
	output      logic [afs_pkg::IDX_W-1:0]      out_index
);

	logic                             lock_valid_q;
	logic [afs_pkg::IDX_W-1:0]        locked_face_q;
	logic                             out_valid_q, out_found_q;
	logic [afs_pkg::IDX_W-1:0]        out_index_q;

	afs_pkg::mode_t                   mode;
	logic [FACE_SLOTS-1:0]            mask;
	logic signed [afs_pkg::DELTA_W-1:0] delta [FACE_SLOTS];
	logic [afs_pkg::ANG_W-1:0]        mag [FACE_SLOTS];
	logic [FACE_SLOTS-1:0]            cand, win;
	logic signed [afs_pkg::DELTA_W-1:0] leave_pos, leave_neg;
	logic                             got_a, got_b, got_w, got_m;
	logic [afs_pkg::IDX_W-1:0]        idx_a, idx_b, idx_w, idx_m;
	logic [afs_pkg::ANG_W-1:0]        best;
	logic                             sel_found, lock_valid_d;
	logic [afs_pkg::IDX_W-1:0]        sel_index, locked_face_d;
	logic                             take;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_index = out_index_q;

	always_comb begin
		mode      = pop_data[0 +: afs_pkg::MODE_W];
		mask      = pop_data[afs_pkg::MODE_W +: FACE_SLOTS];
		leave_pos = $signed({2'b00, depart_lim});
		leave_neg = -leave_pos;
		got_a = 1'b0; got_b = 1'b0; got_w = 1'b0; got_m = 1'b0;
		idx_a = '0; idx_b = '0; idx_w = '0; idx_m = '0;
		best  = '0;
		for (int i = 0; i < FACE_SLOTS; i++) begin
			delta[i] = $signed(pop_data[afs_pkg::MODE_W + FACE_SLOTS + i * afs_pkg::DELTA_W
				+: afs_pkg::DELTA_W]);
			mag[i]   = delta[i][afs_pkg::DELTA_W-1] ?
				afs_pkg::ANG_W'(-delta[i]) : delta[i][afs_pkg::ANG_W-1:0];
			cand[i]  = mask[i] && (mag[i] <= afs_pkg::LOCK_LIMIT);
			win[i]   = mask[i] && (mag[i] <= {1'b0, approach_lim}) &&
				(((mode.spin == 2'b01) && (delta[i] < leave_pos)) ||
				 (mode.spin[1] && (delta[i] > leave_neg)));
			if (cand[i]) begin
				if (!got_a) begin
					got_a = 1'b1;
					idx_a = afs_pkg::IDX_W'(i);
				end else if (!got_b) begin
					got_b = 1'b1;
					idx_b = afs_pkg::IDX_W'(i);
				end
			end
			if (win[i] && !got_w) begin
				got_w = 1'b1;
				idx_w = afs_pkg::IDX_W'(i);
			end
			if (mask[i] && (!got_m || (mag[i] < best))) begin
				got_m = 1'b1;
				idx_m = afs_pkg::IDX_W'(i);
				best  = mag[i];
			end
		end

		lock_valid_d  = lock_valid_q;
		locked_face_d = locked_face_q;
		sel_found     = 1'b0;
		sel_index     = '0;
		if (mode.lock_mode && !mode.is_outpost) begin
			if (got_b) begin
				if (!(lock_valid_q && ((locked_face_q == idx_a) || (locked_face_q == idx_b))))
				begin
					lock_valid_d  = 1'b1;
					locked_face_d = (mag[idx_a] < mag[idx_b]) ? idx_a : idx_b;
				end
				sel_found = 1'b1;
				sel_index = locked_face_d;
			end else if (got_a) begin
				lock_valid_d = 1'b0;
				sel_found    = 1'b1;
				sel_index    = idx_a;
			end
		end else if (got_w) begin
			sel_found = 1'b1;
			sel_index = idx_w;
		end else if (got_m) begin
			sel_found = 1'b1;
			sel_index = idx_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_valid_q  <= 1'b0;
			locked_face_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				lock_valid_q  <= lock_valid_d;
				locked_face_q <= locked_face_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_found_q <= sel_found;
			out_index_q <= sel_index;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/armor_face_selector.sv */
// armor_face_selector: top level; configuration registers, bearing front,
// entry queue and selection back. Depends on afs_pkg, afs_front, afs_queue, afs_back.
//
//  port group  dir  contents
//  s_*         in   target item: centre, face yaws, face count, spin; tuser mode flags
//  m_*         out  selection: face index in tdata, found in tuser
//  cfg_*       in   register write: approach window (0), departure limit (1)
//
// The front takes a new item only after it has pushed the last one, held by the
// one-step-per-cycle CORDIC loop. The back turns out one result per cycle from the
// queue while m_tready is high.
// Reset clears the lock state, the queue and both valids; registers return to 910.
// A stalled m_tready fills the queue, then holds the front in its push state.
`default_nettype none

module armor_face_selector #(
	parameter int FACE_SLOTS   = afs_pkg::FACE_SLOTS_DEF,
	parameter int CORDIC_STEPS = afs_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = afs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// center_x[23:0], center_y[47:24], face_yaw_0..3[111:48], face_count[114:112],
	// spin_sign[116:115], zero pad[119:117]
	input  wire logic [afs_pkg::S_TDATA_W-1:0]     s_tdata,
	// lock_mode[0], is_outpost[1]
	input  wire logic [afs_pkg::S_TUSER_W-1:0]     s_tuser,
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// face_index[1:0], zero pad[7:2]
	output      logic [afs_pkg::M_TDATA_W-1:0]     m_tdata,
	// found[0]
	output      logic [afs_pkg::M_TUSER_W-1:0]     m_tuser,
	input  wire logic                              cfg_we,
	input  wire logic [afs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [afs_pkg::CFG_W-1:0]         cfg_data
);

	localparam int ENTRY_W = FACE_SLOTS * afs_pkg::DELTA_W + FACE_SLOTS + afs_pkg::MODE_W;

	logic [afs_pkg::CFG_W-1:0] approach_lim_q, depart_lim_q;
	logic                      push_valid, push_ready, pop_valid, pop_ready;
	logic [ENTRY_W-1:0]        push_data, pop_data;
	logic                      found;
	logic [afs_pkg::IDX_W-1:0] face_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			approach_lim_q <= afs_pkg::COMING_RST;
			depart_lim_q   <= afs_pkg::LEAVING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				afs_pkg::REG_COMING:  approach_lim_q <= cfg_data;
				afs_pkg::REG_LEAVING: depart_lim_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	afs_front #(
		.FACE_SLOTS   (FACE_SLOTS),
		.CORDIC_STEPS (CORDIC_STEPS),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.in_user    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	afs_queue #(
		.DEPTH   (QUEUE_DEPTH),
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	afs_back #(
		.FACE_SLOTS (FACE_SLOTS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.approach_lim (approach_lim_q),
		.depart_lim   (depart_lim_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_found    (found),
		.out_index    (face_index)
	);

	assign m_tdata = {(afs_pkg::M_TDATA_W - afs_pkg::IDX_W)'(0), face_index};
	assign m_tuser = found;

endmodule

`default_nettype wire

/* tb/sv/afs_selection_checker.sv */
// afs_selection_checker: watches the target, selection and register write channels of
// armor_face_selector, predicts each selection and compares it with what comes out.
// Depends on afs_pkg for widths, field positions and register indexes.

module afs_selection_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [afs_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [afs_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [afs_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic [afs_pkg::M_TUSER_W-1:0] m_tuser,
	input  wire logic                          cfg_we,
	input  wire logic [afs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [afs_pkg::CFG_W-1:0]     cfg_data,
	output int                                 errors,
	output int                                 pending
);
	import afs_pkg::*;

	localparam int BEARING_STEPS = 16;

	typedef struct packed {
		logic       found;
		logic [1:0] face;
	} pick_t;

	pick_t picks_due[$];
	int    coming_win  = 910;
	int    leaving_lim = 910;
	logic  lock_held   = 1'b0;
	logic  [1:0] lock_face = 2'd0;
	int    fails       = 0;

	// atan(2^-i) in 2^-24 turn
	function automatic logic [ZW-1:0] turn_step(input int i);
		case (i)
			0:  return 24'd2097152;
			1:  return 24'd1238021;
			2:  return 24'd654136;
			3:  return 24'd332050;
			4:  return 24'd166669;
			5:  return 24'd83416;
			6:  return 24'd41718;
			7:  return 24'd20860;
			8:  return 24'd10430;
			9:  return 24'd5215;
			10: return 24'd2608;
			11: return 24'd1304;
			12: return 24'd652;
			13: return 24'd326;
			14: return 24'd163;
			15: return 24'd81;
			default: return 24'd0;
		endcase
	endfunction

	function automatic logic [ANG_W-1:0] centre_bearing(input logic signed [XY_W-1:0] cx,
			input logic signed [XY_W-1:0] cy);
		longint x, y, dx, dy;
		logic [ZW-1:0] z, zr;
		int i;
		x = cx;
		y = cy;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 24'h800000;
		end
		for (i = 0; i < BEARING_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + turn_step(i);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - turn_step(i);
			end
		end
		zr = z + 24'd128;
		return zr[ZW-1:8];
	endfunction

	task automatic predict_pick(input logic [S_TDATA_W-1:0] td,
			input logic [S_TUSER_W-1:0] tu, output pick_t p);
		logic [ANG_W-1:0] c, dw;
		logic signed [SPIN_W-1:0] spin;
		int n, i, cnt, sel, a, b, best;
		int delta[MAX_FACES];
		int mag[MAX_FACES];
		int cand[MAX_FACES];
		c = centre_bearing(td[CX_LSB +: XY_W], td[CY_LSB +: XY_W]);
		n = td[COUNT_LSB +: COUNT_W];
		if (n > MAX_FACES)
			n = MAX_FACES;
		spin = td[SPIN_LSB +: SPIN_W];
		sel = -1;
		cnt = 0;
		best = 0;
		for (i = 0; i < n; i++) begin
			dw = td[YAW_LSB + ANG_W * i +: ANG_W] - c;
			delta[i] = dw;
			if (delta[i] > 32768)
				delta[i] = delta[i] - 65536;
			mag[i] = (delta[i] < 0) ? -delta[i] : delta[i];
		end
		if (tu[LOCK_BIT] && !tu[OUTPOST_BIT]) begin
			for (i = 0; i < n; i++)
				if (mag[i] <= int'(LOCK_LIMIT)) begin
					cand[cnt] = i;
					cnt++;
				end
			if (cnt > 1) begin
				a = cand[0];
				b = cand[1];
				if (!(lock_held && (int'(lock_face) == a || int'(lock_face) == b))) begin
					lock_face = (mag[a] < mag[b]) ? a[1:0] : b[1:0];
					lock_held = 1'b1;
				end
				sel = lock_face;
			end else if (cnt == 1) begin
				lock_held = 1'b0;
				sel = cand[0];
			end
		end else begin
			for (i = 0; i < n && sel < 0; i++) begin
				if (mag[i] <= coming_win) begin
					if (spin > 0 && delta[i] < leaving_lim)
						sel = i;
					else if (spin < 0 && delta[i] > -leaving_lim)
						sel = i;
				end
			end
			if (sel < 0)
				for (i = 0; i < n; i++)
					if (sel < 0 || mag[i] < best) begin
						best = mag[i];
						sel = i;
					end
		end
		p.found = (sel >= 0);
		p.face  = (sel >= 0) ? sel[1:0] : 2'd0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pick_t want, got;
		if (!arst_n) begin
			picks_due.delete();
			coming_win  = 910;
			leaving_lim = 910;
			lock_held   = 1'b0;
			lock_face   = 2'd0;
			pending     <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_COMING)
					coming_win = cfg_data;
				else if (cfg_index == REG_LEAVING)
					leaving_lim = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				predict_pick(s_tdata, s_tuser, want);
				picks_due = {picks_due, want};
			end
			if (m_tvalid && m_tready) begin
				got.found = m_tuser[0];
				got.face  = m_tdata[IDX_W-1:0];
				if (picks_due.size() == 0) begin
					if (fails < 10)
						$display("unexpected selection transfer: found=%0d face=%0d",
							got.found, got.face);
					fails++;
				end else begin
					want = picks_due.pop_front();
					if (got.found !== want.found || got.face !== want.face) begin
						if (fails < 10)
							$display("mismatch: exp found=%0d face=%0d, got found=%0d face=%0d",
								want.found, want.face, got.found, got.face);
						fails++;
					end
				end
			end
			pending <= picks_due.size();
		end
		errors <= fails;
	end

endmodule

/* tb/sv/tb_armor_face_selector.sv */
// tb_armor_face_selector: drives target transfers and register writes into
// armor_face_selector under varying idle and stall patterns and gives the verdict.
// Depends on afs_pkg, armor_face_selector and afs_selection_checker.

module tb_armor_face_selector;
	import afs_pkg::*;

	localparam logic [1:0] SPIN_NONE = 2'b00;
	localparam logic [1:0] SPIN_POS  = 2'b01;
	localparam logic [1:0] SPIN_NEG2 = 2'b10;
	localparam logic [1:0] SPIN_NEG  = 2'b11;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [XY_W-1:0]            cx;
		logic [XY_W-1:0]            cy;
		logic [3:0][ANG_W-1:0]      yaw;
		logic [COUNT_W-1:0]         count;
		logic [SPIN_W-1:0]          spin;
		logic                       lock_mode;
		logic                       outpost;
	} target_t;

	localparam int TGT_W = $bits(target_t);

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [S_TUSER_W-1:0]   s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_COMING;
	logic [CFG_W-1:0]       cfg_data  = '0;

	int errors, pending;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_asks   = 0;
	int hold_done   = 0;
	int hold_left   = 0;
	int coming_now  = 910;
	int leaving_now = 910;

	// slowly turning target for realistic sequences
	int trk_left = 0;
	int trk_cx, trk_cy, trk_base, trk_step, trk_count;
	logic [1:0] trk_spin;
	logic trk_lock, trk_out;

	armor_face_selector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	afs_selection_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_done) begin
			m_tready  <= 1'b0;
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic target_t tgt(input logic [XY_W-1:0] cx, input logic [XY_W-1:0] cy,
			input logic [ANG_W-1:0] y0, input logic [ANG_W-1:0] y1,
			input logic [ANG_W-1:0] y2, input logic [ANG_W-1:0] y3,
			input logic [COUNT_W-1:0] count, input logic [1:0] spin,
			input logic lock_mode, input logic outpost);
		target_t t;
		t.cx = cx;
		t.cy = cy;
		t.yaw = {y3, y2, y1, y0};
		t.count = count;
		t.spin = spin;
		t.lock_mode = lock_mode;
		t.outpost = outpost;
		return t;
	endfunction

	function automatic int near_offset();
		int v;
		case ($urandom_range(9))
			0: v = 0;
			1: v = 32768;
			2: v = int'(LOCK_LIMIT);
			3: v = int'(LOCK_LIMIT) + 1;
			4: v = coming_now + int'($urandom_range(2)) - 1;
			5: v = leaving_now + int'($urandom_range(2)) - 1;
			6: v = int'($urandom_range(2000)) - 1000;
			default: v = $urandom_range(65535);
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	function automatic logic [ANG_W-1:0] rough_bearing(input int cx, input int cy);
		int b;
		b = $rtoi($atan2(real'(cy), real'(cx)) * 65536.0 / 6.283185307);
		return b[ANG_W-1:0];
	endfunction

	task automatic gen_target(output target_t t);
		int pick, k, spacing;
		logic [ANG_W-1:0] bear;
		pick = $urandom_range(99);
		if (pick < 65) begin
			if (trk_left == 0) begin
				trk_left  = $urandom_range(30, 5);
				trk_cx    = int'($urandom_range(16000)) - 8000;
				trk_cy    = int'($urandom_range(16000)) - 8000;
				trk_base  = $urandom_range(65535);
				trk_count = $urandom_range(4, 2);
				trk_spin  = SPIN_W'($urandom_range(3));
				trk_step  = $urandom_range(3000, 300);
				trk_lock  = 1'($urandom_range(1));
				trk_out   = ($urandom_range(4) == 0);
			end
			trk_left--;
			if (trk_spin == SPIN_POS)
				trk_base = trk_base + trk_step;
			else if (trk_spin != SPIN_NONE)
				trk_base = trk_base - trk_step;
			trk_cx = trk_cx + int'($urandom_range(100)) - 50;
			trk_cy = trk_cy + int'($urandom_range(100)) - 50;
			bear = rough_bearing(trk_cx, trk_cy);
			spacing = 65536 / trk_count;
			t.cx = XY_W'(trk_cx);
			t.cy = XY_W'(trk_cy);
			for (k = 0; k < 4; k++)
				t.yaw[k] = ANG_W'(int'(bear) + trk_base + k * spacing +
					int'($urandom_range(64)) - 32);
			t.count = COUNT_W'(trk_count);
			t.spin = trk_spin;
			t.lock_mode = trk_lock;
			t.outpost = trk_out;
		end else if (pick < 85) begin
			if ($urandom_range(1)) begin
				t.cx = '0;
				t.cy = '0;
				bear = '0;
			end else begin
				k = int'($urandom_range(200000)) - 100000;
				spacing = int'($urandom_range(200000)) - 100000;
				t.cx = XY_W'(k);
				t.cy = XY_W'(spacing);
				bear = rough_bearing(k, spacing);
			end
			for (k = 0; k < 4; k++)
				t.yaw[k] = ANG_W'(int'(bear) + near_offset());
			t.count = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(7)) :
				COUNT_W'($urandom_range(4, 1));
			t.spin = SPIN_W'($urandom_range(3));
			t.lock_mode = 1'($urandom_range(1));
			t.outpost = ($urandom_range(3) == 0);
		end else begin
			t = TGT_W'({$urandom, $urandom, $urandom, $urandom});
		end
	endtask

	task automatic send_target(input target_t t);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tdata  <= {3'b000, t.spin, t.count, t.yaw, t.cy, t.cx};
		s_tuser  <= {t.outpost, t.lock_mode};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every selection has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_windows(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] l);
		cfg_we    <= 1'b1;
		cfg_index <= REG_COMING;
		cfg_data  <= c;
		@(posedge clk);
		cfg_index <= REG_LEAVING;
		cfg_data  <= l;
		@(posedge clk);
		cfg_we    <= 1'b0;
		coming_now  = c;
		leaving_now = l;
	endtask

	initial begin
		target_t t;
		int ph;
		logic [CFG_W-1:0] c, l;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty face sets, extreme centres, saturated count
		send_target(tgt(0, 0, 0, 0, 0, 0, 0, SPIN_POS, 0, 0));
		send_target(tgt(0, 0, 0, 0, 0, 0, 0, SPIN_POS, 1, 0));
		send_target(tgt(8388607, 8388607, 32767, -32768, 32767, -32768, 7, SPIN_POS, 0, 0));
		send_target(tgt(-8388608, -8388608, -32768, 32767, 0, 1, 5, SPIN_NEG2, 0, 0));
		send_target(tgt(-8388608, 0, 32768, 0, 16384, -16384, 4, SPIN_NEG, 0, 0));
		send_target(tgt(0, -8388608, -16384, 16384, 0, 32768, 4, SPIN_NONE, 0, 0));
		send_target(tgt(-5, 0, 32768, 32000, -32000, 0, 4, SPIN_POS, 1, 0));
		send_target(tgt(8388607, -8388608, -8192, -8000, 8000, 0, 4, SPIN_NEG, 1, 0));
		send_target(tgt(1, 0, 0, 5, -5, 100, 4, SPIN_POS, 0, 0));
		send_target(tgt(0, 1, 16384, 16380, 16390, 0, 4, SPIN_NEG, 0, 0));
		// lock: tie on first two candidates, hold, relock, single, none
		send_target(tgt(0, 0, 32768, 10921, -10921, 10922, 4, SPIN_POS, 1, 0));
		send_target(tgt(0, 0, 32768, 10921, -10921, 10922, 4, SPIN_POS, 1, 0));
		send_target(tgt(0, 0, 100, -200, 30000, 30000, 4, SPIN_POS, 1, 0));
		send_target(tgt(0, 0, 30000, 5000, 30000, 30000, 4, SPIN_POS, 1, 0));
		send_target(tgt(0, 0, 20000, 20000, 20000, 20000, 4, SPIN_POS, 1, 0));
		send_target(tgt(0, 0, 100, -200, 0, 0, 2, SPIN_NEG, 1, 0));
		send_target(tgt(0, 0, 100, -200, 0, 0, 6, SPIN_NEG, 1, 0));
		send_target(tgt(0, 0, 100, -200, 0, 0, 2, SPIN_NEG, 1, 1));
		// window rule edges
		send_target(tgt(0, 0, 910, -5, 0, 0, 4, SPIN_POS, 0, 0));
		send_target(tgt(0, 0, -910, 900, 0, 0, 4, SPIN_NEG, 0, 0));
		send_target(tgt(0, 0, 500, -300, 300, 2000, 4, SPIN_NONE, 0, 0));
		send_target(tgt(0, 0, -911, 911, -50, 0, 4, SPIN_NEG2, 0, 0));
		send_target(tgt(0, 0, 30000, -32768, 20000, 0, 3, SPIN_POS, 0, 1));
		settle();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin c = 0;     l = 0;     end
				1: begin c = 32767; l = 32767; end
				2: begin c = 32767; l = 0;     end
				3: begin c = 0;     l = 32767; end
				4: begin
					c = CFG_W'($urandom_range(6000));
					l = CFG_W'($urandom_range(6000));
				end
				5: begin
					c = CFG_W'($urandom_range(32767));
					l = CFG_W'($urandom_range(32767));
				end
				6: begin c = 910;   l = 910;   end
				default: begin
					c = CFG_W'($urandom_range(12000));
					l = CFG_W'($urandom_range(4000));
				end
			endcase
			write_windows(c, l);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 67; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 67; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			if (ph == 0)
				hold_asks <= hold_asks + 1;
			repeat (100) begin
				gen_target(t);
				send_target(t);
			end
			settle();
		end

		repeat (CORDIC_STEPS_DEF + 8) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
